// ===== sv/i2cras_pkg.sv =====
// Shared types and codes for the I2C register access sequencer.
`default_nettype none

package i2cras_pkg;

    localparam logic [2:0] KIND_WRITE_REQ     = 3'd0;
    localparam logic [2:0] KIND_READ_REQ      = 3'd1;
    localparam logic [2:0] KIND_START_SENT    = 3'd2;
    localparam logic [2:0] KIND_ADDR_SENT     = 3'd3;
    localparam logic [2:0] KIND_BYTE_RECEIVED = 3'd4;
    localparam logic [2:0] KIND_TX_EMPTY      = 3'd5;
    localparam logic [2:0] KIND_ERROR         = 3'd6;

    typedef enum logic [1:0] {
        STATUS_STANDBY = 2'd0,
        STATUS_BUSY    = 2'd1,
        STATUS_ERROR   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        OP_WRITE,
        OP_READ,
        OP_START,
        OP_ADDR,
        OP_RX,
        OP_TXE,
        OP_ERR,
        OP_NONE
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] byte_a;
        logic [7:0] byte_b;
    } t_cmd;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       ack_enable;
        logic       nack_request;
        logic       stop_request;
        logic       start_request;
        logic       read_valid;
        logic [7:0] read_byte;
        t_status    status;
    } t_res;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

endpackage

`default_nettype wire

// ===== sv/i2cras_queue.sv =====
// Small first-in first-out word queue.
`default_nettype none

module i2cras_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_rd,
    output logic      [WIDTH-1:0] o_rdata,
    output i2cras_pkg::t_qstat    o_stat
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, n_wp;
    logic [AW-1:0]    r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             w_wr_ok;
    logic             w_rd_ok;

    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign w_wr_ok      = i_wr && !o_stat.full;
    assign w_rd_ok      = i_rd && !o_stat.empty;
    assign o_rdata      = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_wr_ok) begin
            n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (w_rd_ok) begin
            n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (w_wr_ok && !w_rd_ok) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_rd_ok && !w_wr_ok) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_ok) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

// ===== sv/i2cras_front.sv =====
// Input side: accepts words and classifies them into commands.
`default_nettype none

module i2cras_front (
    input  wire logic               push,
    output logic                    full,
    input  wire logic [2:0]         i_kind,
    input  wire logic [7:0]         i_reg_addr,
    input  wire logic [7:0]         i_write_data,
    input  wire logic [7:0]         i_rx_byte,
    input  wire i2cras_pkg::t_qstat i_qstat,
    output logic                    o_wr,
    output i2cras_pkg::t_cmd        o_cmd
);

    assign full = i_qstat.full;
    assign o_wr = push && !i_qstat.full;

    always_comb begin
        o_cmd.byte_a = 8'd0;
        o_cmd.byte_b = 8'd0;
        case (i_kind)
            i2cras_pkg::KIND_WRITE_REQ: begin
                o_cmd.op     = i2cras_pkg::OP_WRITE;
                o_cmd.byte_a = i_reg_addr;
                o_cmd.byte_b = i_write_data;
            end
            i2cras_pkg::KIND_READ_REQ: begin
                o_cmd.op     = i2cras_pkg::OP_READ;
                o_cmd.byte_a = i_reg_addr;
            end
            i2cras_pkg::KIND_START_SENT:    o_cmd.op = i2cras_pkg::OP_START;
            i2cras_pkg::KIND_ADDR_SENT:     o_cmd.op = i2cras_pkg::OP_ADDR;
            i2cras_pkg::KIND_BYTE_RECEIVED: begin
                o_cmd.op     = i2cras_pkg::OP_RX;
                o_cmd.byte_a = i_rx_byte;
            end
            i2cras_pkg::KIND_TX_EMPTY:      o_cmd.op = i2cras_pkg::OP_TXE;
            i2cras_pkg::KIND_ERROR:         o_cmd.op = i2cras_pkg::OP_ERR;
            default:                        o_cmd.op = i2cras_pkg::OP_NONE;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/i2cras_back.sv =====
// Execution side: transaction state and command generation per command word.
`default_nettype none

module i2cras_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_device_address_we,
    input  wire logic [6:0]         i_device_address,
    input  wire i2cras_pkg::t_cmd   i_cmd,
    input  wire i2cras_pkg::t_qstat i_cmd_stat,
    input  wire i2cras_pkg::t_qstat i_res_stat,
    output logic                    o_cmd_pop,
    output logic                    o_res_push,
    output i2cras_pkg::t_res        o_res
);

    logic [6:0]          r_dev;
    logic [7:0]          r_buf0, n_buf0;
    logic [7:0]          r_buf1, n_buf1;
    logic [1:0]          r_idx, n_idx;
    logic [1:0]          r_wlen, n_wlen;
    logic                r_rlen, n_rlen;
    logic                r_req_rd, n_req_rd;
    logic                r_ph_rd, n_ph_rd;
    i2cras_pkg::t_status r_stat, n_stat;
    logic                w_fire;
    logic [7:0]          w_buf_at_idx;
    logic [1:0]          w_idx_inc;

    assign w_fire     = !i_cmd_stat.empty && !i_res_stat.full;
    assign o_cmd_pop  = w_fire;
    assign o_res_push = w_fire;
    assign w_idx_inc  = r_idx + 2'd1;

    always_comb begin
        case (r_idx)
            2'd0:    w_buf_at_idx = r_buf0;
            2'd1:    w_buf_at_idx = r_buf1;
            default: w_buf_at_idx = 8'd0;
        endcase
    end

    always_comb begin
        n_buf0   = r_buf0;
        n_buf1   = r_buf1;
        n_idx    = r_idx;
        n_wlen   = r_wlen;
        n_rlen   = r_rlen;
        n_req_rd = r_req_rd;
        n_ph_rd  = r_ph_rd;
        n_stat   = r_stat;
        o_res    = '0;
        case (i_cmd.op)
            i2cras_pkg::OP_WRITE: begin
                n_req_rd = 1'b0;
                n_wlen   = 2'd2;
                n_buf0   = i_cmd.byte_a;
                n_buf1   = i_cmd.byte_b;
                n_idx    = 2'd0;
                n_ph_rd  = 1'b0;
                n_stat   = i2cras_pkg::STATUS_BUSY;
                o_res.start_request = 1'b1;
            end
            i2cras_pkg::OP_READ: begin
                n_req_rd = 1'b1;
                n_rlen   = 1'b1;
                n_wlen   = 2'd1;
                n_buf0   = i_cmd.byte_a;
                n_idx    = 2'd0;
                n_ph_rd  = 1'b0;
                n_stat   = i2cras_pkg::STATUS_BUSY;
                o_res.start_request = 1'b1;
            end
            i2cras_pkg::OP_START: begin
                o_res.tx_valid = 1'b1;
                o_res.tx_byte  = {r_dev, r_ph_rd};
            end
            i2cras_pkg::OP_ADDR: begin
                n_idx            = 2'd0;
                o_res.ack_enable = 1'b1;
                if (!r_ph_rd) begin
                    if (r_wlen != 2'd0) begin
                        o_res.tx_valid = 1'b1;
                        o_res.tx_byte  = r_buf0;
                        n_idx          = 2'd1;
                    end
                end else if (r_rlen) begin
                    o_res.nack_request = 1'b1;
                    o_res.stop_request = 1'b1;
                end
            end
            i2cras_pkg::OP_RX: begin
                if (r_rlen) begin
                    n_ph_rd = 1'b0;
                end
                if (r_idx == 2'd0) begin
                    n_buf0 = i_cmd.byte_a;
                end
                if (r_idx == 2'd1) begin
                    n_buf1 = i_cmd.byte_a;
                end
                n_idx = w_idx_inc;
                if (w_idx_inc == {1'b0, r_rlen}) begin
                    n_stat = i2cras_pkg::STATUS_STANDBY;
                end
                o_res.read_valid = 1'b1;
                o_res.read_byte  = i_cmd.byte_a;
            end
            i2cras_pkg::OP_TXE: begin
                if (r_idx < r_wlen) begin
                    if (!r_req_rd && ({1'b0, r_idx} + 3'd1 == {1'b0, r_wlen})) begin
                        o_res.stop_request = 1'b1;
                        n_rlen             = 1'b0;
                        n_wlen             = 2'd0;
                    end
                    o_res.tx_valid = 1'b1;
                    o_res.tx_byte  = w_buf_at_idx;
                    n_idx          = w_idx_inc;
                end else if (r_req_rd) begin
                    n_ph_rd             = 1'b1;
                    o_res.start_request = 1'b1;
                end else begin
                    n_stat = i2cras_pkg::STATUS_STANDBY;
                end
            end
            i2cras_pkg::OP_ERR: begin
                n_stat = i2cras_pkg::STATUS_ERROR;
            end
            default: begin
            end
        endcase
        o_res.status = n_stat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev    <= 7'd0;
            r_idx    <= 2'd0;
            r_wlen   <= 2'd0;
            r_rlen   <= 1'b0;
            r_req_rd <= 1'b0;
            r_ph_rd  <= 1'b0;
            r_stat   <= i2cras_pkg::STATUS_STANDBY;
        end else begin
            if (i_device_address_we) begin
                r_dev <= i_device_address;
            end
            if (w_fire) begin
                r_idx    <= n_idx;
                r_wlen   <= n_wlen;
                r_rlen   <= n_rlen;
                r_req_rd <= n_req_rd;
                r_ph_rd  <= n_ph_rd;
                r_stat   <= n_stat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_buf0 <= n_buf0;
            r_buf1 <= n_buf1;
        end
    end

endmodule

`default_nettype wire

// ===== sv/i2c_master_register_access_sequencer_unit.sv =====
// I2C master register access sequencer: top level.
//
// Input channel: drive kind and the request or event bytes with push high; the
// word is taken at a clock edge where push is high and full is low.
// Result channel: while empty is low the oldest result is on the o_ ports; it is
// taken at a clock edge where pop is high and empty is low.
// Device address register: written at an edge with i_device_address_we high; the user
// must write it only while no words are in flight, as the block does not enforce this.
// A word taken into the command queue is executed against the transaction state once
// it is at the head of that queue and the result queue has room; its result is visible from that edge on.
// Throughput: one word per cycle while the result queue has room, set by the execution stage.
// A command queue of CMD_DEPTH words and a result queue of RES_DEPTH words sit
// between the input, the execution stage and the output; if pop stays low the
// result queue fills, execution stops, and full rises once the command queue
// fills too. No word is lost or repeated.
// Reset (synchronous, active low): both queues empty, status standby, device
// address zero.
`default_nettype none

module i2c_master_register_access_sequencer_unit #(
    parameter int unsigned CMD_DEPTH = 2,
    parameter int unsigned RES_DEPTH = 2
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_device_address_we,
    input  wire logic [6:0] i_device_address,
    input  wire logic       push,
    output logic            full,
    input  wire logic [2:0] i_kind,
    input  wire logic [7:0] i_reg_addr,
    input  wire logic [7:0] i_write_data,
    input  wire logic [7:0] i_rx_byte,
    output logic            empty,
    input  wire logic       pop,
    output logic            o_tx_valid,
    output logic [7:0]      o_tx_byte,
    output logic            o_ack_enable,
    output logic            o_nack_request,
    output logic            o_stop_request,
    output logic            o_start_request,
    output logic            o_read_valid,
    output logic [7:0]      o_read_byte,
    output logic [1:0]      o_status
);

    localparam int unsigned CMD_W = $bits(i2cras_pkg::t_cmd);
    localparam int unsigned RES_W = $bits(i2cras_pkg::t_res);

    i2cras_pkg::t_cmd   w_cmd_in;
    i2cras_pkg::t_cmd   w_cmd_out;
    i2cras_pkg::t_res   w_res_in;
    i2cras_pkg::t_res   w_res_out;
    i2cras_pkg::t_qstat w_cmd_stat;
    i2cras_pkg::t_qstat w_res_stat;
    logic               w_cmd_wr;
    logic               w_cmd_pop;
    logic               w_res_push;
    logic [CMD_W-1:0]   w_cmd_rdata;
    logic [RES_W-1:0]   w_res_rdata;

    i2cras_front u_front (
        .push         (push),
        .full         (full),
        .i_kind       (i_kind),
        .i_reg_addr   (i_reg_addr),
        .i_write_data (i_write_data),
        .i_rx_byte    (i_rx_byte),
        .i_qstat      (w_cmd_stat),
        .o_wr         (w_cmd_wr),
        .o_cmd        (w_cmd_in)
    );

    i2cras_queue #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_cmd_wr),
        .i_wdata (w_cmd_in),
        .i_rd    (w_cmd_pop),
        .o_rdata (w_cmd_rdata),
        .o_stat  (w_cmd_stat)
    );

    assign w_cmd_out = i2cras_pkg::t_cmd'(w_cmd_rdata);

    i2cras_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_device_address_we (i_device_address_we),
        .i_device_address    (i_device_address),
        .i_cmd               (w_cmd_out),
        .i_cmd_stat          (w_cmd_stat),
        .i_res_stat          (w_res_stat),
        .o_cmd_pop           (w_cmd_pop),
        .o_res_push          (w_res_push),
        .o_res               (w_res_in)
    );

    i2cras_queue #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_res_push),
        .i_wdata (w_res_in),
        .i_rd    (pop),
        .o_rdata (w_res_rdata),
        .o_stat  (w_res_stat)
    );

    assign w_res_out       = i2cras_pkg::t_res'(w_res_rdata);
    assign empty           = w_res_stat.empty;
    assign o_tx_valid      = w_res_out.tx_valid;
    assign o_tx_byte       = w_res_out.tx_byte;
    assign o_ack_enable    = w_res_out.ack_enable;
    assign o_nack_request  = w_res_out.nack_request;
    assign o_stop_request  = w_res_out.stop_request;
    assign o_start_request = w_res_out.start_request;
    assign o_read_valid    = w_res_out.read_valid;
    assign o_read_byte     = w_res_out.read_byte;
    assign o_status        = w_res_out.status;

endmodule

`default_nettype wire

// ===== sv/i2cras_checker.sv =====
// Port-level checks for the I2C register access sequencer, bound to the top level.
`default_nettype none

module i2cras_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       full,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic       o_tx_valid,
    input wire logic [7:0] o_tx_byte,
    input wire logic       o_ack_enable,
    input wire logic       o_nack_request,
    input wire logic       o_stop_request,
    input wire logic       o_start_request,
    input wire logic       o_read_valid
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_tx_byte) && $stable(o_tx_valid))
        else $error("stalled result changed");

    a_nack_with_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_nack_request |-> o_stop_request && o_ack_enable && !o_tx_valid)
        else $error("nack without stop and ack");

    a_read_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_read_valid |-> !o_tx_valid && !o_start_request && !o_ack_enable)
        else $error("received byte mixed with transmit commands");

    a_idle_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_tx_valid |-> o_tx_byte == 8'd0)
        else $error("transmit byte set without transmit valid");

endmodule

bind i2c_master_register_access_sequencer_unit i2cras_checker u_i2cras_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .full            (full),
    .empty           (empty),
    .pop             (pop),
    .o_tx_valid      (o_tx_valid),
    .o_tx_byte       (o_tx_byte),
    .o_ack_enable    (o_ack_enable),
    .o_nack_request  (o_nack_request),
    .o_stop_request  (o_stop_request),
    .o_start_request (o_start_request),
    .o_read_valid    (o_read_valid)
);

`default_nettype wire

// ===== dv/i2c_master_register_access_sequencer_checker.sv =====
// Checker for the I2C register access sequencer: predicts and compares every result word.
module i2c_master_register_access_sequencer_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_addr,
    input  logic       i_push,
    input  logic       i_full,
    input  logic [2:0] i_kind,
    input  logic [7:0] i_reg_addr,
    input  logic [7:0] i_write_data,
    input  logic [7:0] i_rx_byte,
    input  logic       i_empty,
    input  logic       i_pop,
    input  logic       i_tx_valid,
    input  logic [7:0] i_tx_byte,
    input  logic       i_ack_enable,
    input  logic       i_nack_request,
    input  logic       i_stop_request,
    input  logic       i_start_request,
    input  logic       i_read_valid,
    input  logic [7:0] i_read_byte,
    input  logic [1:0] i_status,
    output int         o_pending,
    output int         o_fail_count,
    output int         o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [6:0]          dev_addr;
    logic [7:0]          txn_buf [2];
    logic [1:0]          txn_idx;
    logic [1:0]          txn_wlen;
    logic                txn_rlen;
    logic                txn_is_read;
    logic                txn_rx_phase;
    i2cras_pkg::t_status txn_status;
    i2cras_pkg::t_res    bus_cmds_q[$];
    i2cras_pkg::t_res    want;
    int                  fails = 0;
    int                  checked = 0;

    assign o_fail_count = fails;
    assign o_checked    = checked;

    function automatic i2cras_pkg::t_res advance_transaction(input logic [2:0] kind,
                                                             input logic [7:0] reg_b,
                                                             input logic [7:0] dat_b,
                                                             input logic [7:0] rx_b);
        i2cras_pkg::t_res r;
        r = '0;
        case (kind)
            i2cras_pkg::KIND_WRITE_REQ: begin
                txn_is_read     = 1'b0;
                txn_wlen        = 2'd2;
                txn_buf[0]      = reg_b;
                txn_buf[1]      = dat_b;
                txn_idx         = 2'd0;
                txn_rx_phase    = 1'b0;
                txn_status      = i2cras_pkg::STATUS_BUSY;
                r.start_request = 1'b1;
            end
            i2cras_pkg::KIND_READ_REQ: begin
                txn_is_read     = 1'b1;
                txn_rlen        = 1'b1;
                txn_wlen        = 2'd1;
                txn_buf[0]      = reg_b;
                txn_idx         = 2'd0;
                txn_rx_phase    = 1'b0;
                txn_status      = i2cras_pkg::STATUS_BUSY;
                r.start_request = 1'b1;
            end
            i2cras_pkg::KIND_START_SENT: begin
                r.tx_valid = 1'b1;
                r.tx_byte  = {dev_addr, txn_rx_phase};
            end
            i2cras_pkg::KIND_ADDR_SENT: begin
                txn_idx      = 2'd0;
                r.ack_enable = 1'b1;
                if (!txn_rx_phase) begin
                    if (txn_wlen != 2'd0) begin
                        r.tx_valid = 1'b1;
                        r.tx_byte  = txn_buf[0];
                        txn_idx    = 2'd1;
                    end
                end else if (txn_rlen) begin
                    r.nack_request = 1'b1;
                    r.stop_request = 1'b1;
                end
            end
            i2cras_pkg::KIND_BYTE_RECEIVED: begin
                if (txn_rlen) begin
                    txn_rx_phase = 1'b0;
                end
                if (!txn_idx[1]) begin
                    txn_buf[txn_idx[0]] = rx_b;
                end
                txn_idx = txn_idx + 2'd1;
                if (txn_idx == {1'b0, txn_rlen}) begin
                    txn_status = i2cras_pkg::STATUS_STANDBY;
                end
                r.read_valid = 1'b1;
                r.read_byte  = rx_b;
            end
            i2cras_pkg::KIND_TX_EMPTY: begin
                if (txn_idx < txn_wlen) begin
                    if (!txn_is_read && (txn_idx + 2'd1) == txn_wlen) begin
                        r.stop_request = 1'b1;
                        txn_rlen       = 1'b0;
                        txn_wlen       = 2'd0;
                    end
                    r.tx_valid = 1'b1;
                    r.tx_byte  = txn_idx[1] ? 8'h00 : txn_buf[txn_idx[0]];
                    txn_idx    = txn_idx + 2'd1;
                end else if (txn_is_read) begin
                    txn_rx_phase    = 1'b1;
                    r.start_request = 1'b1;
                end else begin
                    txn_status = i2cras_pkg::STATUS_STANDBY;
                end
            end
            i2cras_pkg::KIND_ERROR: begin
                txn_status = i2cras_pkg::STATUS_ERROR;
            end
            default: begin
            end
        endcase
        r.status = txn_status;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] result %0d: %s", $realtime, checked, msg);
        fails++;
    endtask

    task automatic check_field(input string name, input int got, input int exp_val);
        if (got != exp_val) begin
            report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, exp_val));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dev_addr     = '0;
            txn_buf[0]   = '0;
            txn_buf[1]   = '0;
            txn_idx      = '0;
            txn_wlen     = '0;
            txn_rlen     = 1'b0;
            txn_is_read  = 1'b0;
            txn_rx_phase = 1'b0;
            txn_status   = i2cras_pkg::STATUS_STANDBY;
            bus_cmds_q.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (bus_cmds_q.size() == 0) begin
                    report_mismatch("result word with no expectation pending");
                end else begin
                    want = bus_cmds_q.pop_front();
                    check_field("tx_valid", i_tx_valid, want.tx_valid);
                    check_field("tx_byte", i_tx_byte, want.tx_byte);
                    check_field("ack_enable", i_ack_enable, want.ack_enable);
                    check_field("nack_request", i_nack_request, want.nack_request);
                    check_field("stop_request", i_stop_request, want.stop_request);
                    check_field("start_request", i_start_request, want.start_request);
                    check_field("read_valid", i_read_valid, want.read_valid);
                    check_field("read_byte", i_read_byte, want.read_byte);
                    check_field("status", i_status, want.status);
                end
                checked++;
            end
            if (i_cfg_we) begin
                dev_addr = i_cfg_addr;
            end
            if (i_push && !i_full) begin
                bus_cmds_q.push_back(advance_transaction(i_kind, i_reg_addr, i_write_data,
                                                         i_rx_byte));
            end
        end
        o_pending <= bus_cmds_q.size();
    end

endmodule

// ===== dv/i2c_master_register_access_sequencer_unit_test.sv =====
// Testbench top for the I2C register access sequencer: clock, reset, stimulus and verdict.
module i2c_master_register_access_sequencer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] KIND_UNUSED = 3'd7;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_WORDS = 210;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_device_address_we = 1'b0;
    logic [6:0] i_device_address = '0;
    logic       push = 1'b0;
    logic [2:0] i_kind = '0;
    logic [7:0] i_reg_addr = '0;
    logic [7:0] i_write_data = '0;
    logic [7:0] i_rx_byte = '0;
    logic       pop = 1'b0;
    logic       full;
    logic       empty;
    logic       o_tx_valid;
    logic [7:0] o_tx_byte;
    logic       o_ack_enable;
    logic       o_nack_request;
    logic       o_stop_request;
    logic       o_start_request;
    logic       o_read_valid;
    logic [7:0] o_read_byte;
    logic [1:0] o_status;

    logic       calm = 1'b0;
    int         pending;
    int         fail_count;
    int         checked;
    int         stall_cycles = 0;
    int         words_sent = 0;
    int         writes_run = 0;
    int         reads_run = 0;
    int         cut_runs = 0;
    int         noise_runs = 0;

    i2c_master_register_access_sequencer_unit u_dut (.*);

    i2c_master_register_access_sequencer_checker u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_device_address_we),
        .i_cfg_addr      (i_device_address),
        .i_push          (push),
        .i_full          (full),
        .i_kind          (i_kind),
        .i_reg_addr      (i_reg_addr),
        .i_write_data    (i_write_data),
        .i_rx_byte       (i_rx_byte),
        .i_empty         (empty),
        .i_pop           (pop),
        .i_tx_valid      (o_tx_valid),
        .i_tx_byte       (o_tx_byte),
        .i_ack_enable    (o_ack_enable),
        .i_nack_request  (o_nack_request),
        .i_stop_request  (o_stop_request),
        .i_start_request (o_start_request),
        .i_read_valid    (o_read_valid),
        .i_read_byte     (o_read_byte),
        .i_status        (o_status),
        .o_pending       (pending),
        .o_fail_count    (fail_count),
        .o_checked       (checked)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (calm) begin
            pop <= 1'b1;
        end else begin
            pop <= ($urandom_range(0, 99) >= 26);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_word(input logic [2:0] kind, input logic [7:0] reg_b,
                             input logic [7:0] dat_b, input logic [7:0] rx_b);
        while (!calm && $urandom_range(0, 99) < 26) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        i_kind       <= kind;
        i_reg_addr   <= reg_b;
        i_write_data <= dat_b;
        i_rx_byte    <= rx_b;
        push         <= 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic drain_results();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic set_device_address(input logic [6:0] addr);
        drain_results();
        i_device_address    <= addr;
        i_device_address_we <= 1'b1;
        @(posedge i_clk);
        i_device_address_we <= 1'b0;
    endtask

    task automatic run_transaction();
        logic [2:0] plan[$];
        int         pick;
        int         cut;
        int         n;
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
            if ($urandom_range(0, 1) == 1) begin
                plan = {i2cras_pkg::KIND_WRITE_REQ, i2cras_pkg::KIND_START_SENT,
                        i2cras_pkg::KIND_ADDR_SENT, i2cras_pkg::KIND_TX_EMPTY,
                        i2cras_pkg::KIND_TX_EMPTY};
                writes_run++;
            end else begin
                plan = {i2cras_pkg::KIND_READ_REQ, i2cras_pkg::KIND_START_SENT,
                        i2cras_pkg::KIND_ADDR_SENT, i2cras_pkg::KIND_TX_EMPTY,
                        i2cras_pkg::KIND_TX_EMPTY, i2cras_pkg::KIND_START_SENT,
                        i2cras_pkg::KIND_ADDR_SENT, i2cras_pkg::KIND_BYTE_RECEIVED};
                reads_run++;
            end
            if (pick >= 70) begin
                // cut short and inject a fault or a stray event
                cut = $urandom_range(1, plan.size() - 1);
                while (plan.size() > cut) void'(plan.pop_back());
                plan.push_back(($urandom_range(0, 1) == 1) ? i2cras_pkg::KIND_ERROR
                                                           : 3'($urandom_range(2, 7)));
                cut_runs++;
            end else if ($urandom_range(0, 3) == 0) begin
                plan.push_back(i2cras_pkg::KIND_TX_EMPTY);
            end
        end else begin
            n = $urandom_range(1, 4);
            repeat (n) plan.push_back(3'($urandom_range(0, 7)));
            noise_runs++;
        end
        foreach (plan[i]) begin
            send_word(plan[i], 8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        int         goal;
        bit         paused;
        logic [6:0] addr;
        paused = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_device_address(7'h7F);
        send_word(i2cras_pkg::KIND_WRITE_REQ, 8'hFF, 8'h00, 8'h00);
        send_word(i2cras_pkg::KIND_START_SENT, 8'h00, 8'h00, 8'h00);
        send_word(i2cras_pkg::KIND_ADDR_SENT, 8'h00, 8'h00, 8'h00);
        send_word(i2cras_pkg::KIND_TX_EMPTY, 8'h00, 8'h00, 8'h00);
        send_word(i2cras_pkg::KIND_TX_EMPTY, 8'h00, 8'h00, 8'h00);
        send_word(i2cras_pkg::KIND_READ_REQ, 8'h00, 8'hFF, 8'h00);
        send_word(i2cras_pkg::KIND_START_SENT, 8'h00, 8'h00, 8'h00);
        send_word(i2cras_pkg::KIND_ADDR_SENT, 8'h00, 8'h00, 8'h00);
        send_word(i2cras_pkg::KIND_TX_EMPTY, 8'h00, 8'h00, 8'h00);
        send_word(i2cras_pkg::KIND_TX_EMPTY, 8'h00, 8'h00, 8'h00);
        send_word(i2cras_pkg::KIND_START_SENT, 8'h00, 8'h00, 8'h00);
        send_word(i2cras_pkg::KIND_ADDR_SENT, 8'h00, 8'h00, 8'h00);
        send_word(i2cras_pkg::KIND_BYTE_RECEIVED, 8'h00, 8'h00, 8'hFF);
        // out-of-order receives walk the index past the buffer and wrap it
        send_word(i2cras_pkg::KIND_BYTE_RECEIVED, 8'h00, 8'h00, 8'h00);
        send_word(i2cras_pkg::KIND_BYTE_RECEIVED, 8'h00, 8'h00, 8'hAA);
        send_word(i2cras_pkg::KIND_BYTE_RECEIVED, 8'h00, 8'h00, 8'h55);
        send_word(i2cras_pkg::KIND_ERROR, 8'h00, 8'h00, 8'h00);
        send_word(i2cras_pkg::KIND_START_SENT, 8'h00, 8'h00, 8'h00);
        send_word(KIND_UNUSED, 8'hFF, 8'hFF, 8'hFF);
        send_word(i2cras_pkg::KIND_WRITE_REQ, 8'h00, 8'hFF, 8'h00);
        send_word(i2cras_pkg::KIND_READ_REQ, 8'h5A, 8'h00, 8'h00);
        send_word(i2cras_pkg::KIND_TX_EMPTY, 8'h00, 8'h00, 8'h00);
        send_word(i2cras_pkg::KIND_TX_EMPTY, 8'h00, 8'h00, 8'h00);
        send_word(KIND_UNUSED, 8'h00, 8'h00, 8'h00);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: addr = 7'h00;
                2: addr = 7'h7F;
                default: addr = 7'($urandom);
            endcase
            set_device_address(addr);
            calm <= (ph == 2);
            goal = words_sent + PHASE_WORDS;
            while (words_sent < goal) begin
                run_transaction();
                if (ph == 1 && !paused && words_sent > goal - PHASE_WORDS / 2) begin
                    drain_results();
                    paused = 1'b1;
                end
            end
        end

        drain_results();
        calm <= 1'b0;
        repeat (4) @(posedge i_clk);

        $display("Run covered %0d words: %0d write and %0d read transactions, %0d cut short,",
                 words_sent, writes_run, reads_run, cut_runs);
        $display("%0d noise runs, device addresses 0x00, 0x7f and random; %0d results checked.",
                 noise_runs, checked);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
